// ----- hdl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

// property a implies b on the same clock edge
`define ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

`endif

// ----- hdl/ggnh_pkg.sv -----
package ggnh_pkg;

	localparam logic [2:0] FUNC_ADD   = 3'd0;
	localparam logic [2:0] FUNC_DEL   = 3'd1;
	localparam logic [2:0] FUNC_CHECK = 3'd2;
	localparam logic [2:0] FUNC_QUERY = 3'd3;
	localparam logic [2:0] FUNC_CLEAR = 3'd4;

	localparam logic [31:0] LIFETIME_RESET = 32'd600000;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture request fields, start scan
		logic step;     // process current slot
		logic own_step; // compute own distance into compare slot
		logic finish;   // commit and register result
	} ggnh_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last; // current slot is the last one
	} ggnh_sts_t;

endpackage

// ----- hdl/ggnh_ctrl.sv -----
module ggnh_ctrl
	import ggnh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ggnh_sts_t sts,
	output ggnh_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_OWN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_SCAN;
				ST_SCAN: if (sts.last) state_q <= ST_OWN;
				ST_OWN:  state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cmd.load     = (state_q == ST_IDLE) && start;
	assign cmd.step     = (state_q == ST_SCAN);
	assign cmd.own_step = (state_q == ST_OWN);
	assign cmd.finish   = (state_q == ST_DONE);

endmodule

// ----- hdl/ggnh_dp.sv -----
module ggnh_dp
	import ggnh_pkg::*;
#(
	parameter int NEIGHBOR_SLOTS = 32,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ggnh_cmd_t                    cmd,
	output ggnh_sts_t                    sts,
	input  logic                         cfg_we,
	input  logic [31:0]                  cfg_wdata,
	input  logic [2:0]                   func,
	input  logic [31:0]                  node_id,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] own_x,
	input  logic signed [COORD_BITS-1:0] own_y,
	input  logic [47:0]                  now_time,
	output logic [31:0]                  next_hop,
	output logic                         hop_found,
	output logic                         is_member,
	output logic                         table_full_drop,
	output logic                         done
);

	localparam int IW = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
	localparam int DW = COORD_BITS + 1;
	localparam int SW = 2 * DW + 1;

	logic [NEIGHBOR_SLOTS-1:0] valid_q;
	logic [31:0]               addr_mem [NEIGHBOR_SLOTS];
	logic [COORD_BITS-1:0]     x_mem [NEIGHBOR_SLOTS];
	logic [COORD_BITS-1:0]     y_mem [NEIGHBOR_SLOTS];
	logic [47:0]               stamp_mem [NEIGHBOR_SLOTS];

	logic [31:0] life_q;
	logic [2:0]  func_q;
	logic [31:0] id_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, ox_q, oy_q;
	logic [47:0] now_q;
	logic [IW-1:0] idx_q;

	logic          match_q, free_q, have_q;
	logic [IW-1:0] match_idx_q, free_idx_q;
	logic [SW-1:0] best_q;
	logic [31:0]   best_id_q;
	logic [SW-1:0] own_q;

	logic [31:0] r_addr;
	logic signed [COORD_BITS-1:0] r_x, r_y, dsx, dsy;
	logic [47:0] r_stamp;
	logic        live, expired;
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] adx, ady;
	logic [SW-1:0] d;

	assign r_addr  = addr_mem[idx_q];
	assign r_x     = x_mem[idx_q];
	assign r_y     = y_mem[idx_q];
	assign r_stamp = stamp_mem[idx_q];
	assign expired = ({1'b0, r_stamp} + {17'd0, life_q}) <= {1'b0, now_q};
	assign live    = valid_q[idx_q] && !((func_q == FUNC_QUERY) && expired);

	// same subtract and square unit serves slots and own position
	assign dsx = cmd.own_step ? ox_q : r_x;
	assign dsy = cmd.own_step ? oy_q : r_y;
	assign dx  = DW'(dsx) - DW'(px_q);
	assign dy  = DW'(dsy) - DW'(py_q);
	assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign d   = SW'(adx) * SW'(adx) + SW'(ady) * SW'(ady);

	assign sts.last = (idx_q == IW'(NEIGHBOR_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q  <= LIFETIME_RESET;
			valid_q <= '0;
			idx_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) life_q <= cfg_wdata;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.step) begin
				if (!sts.last) idx_q <= idx_q + 1'b1;
				if (func_q == FUNC_QUERY && valid_q[idx_q] && expired)
					valid_q[idx_q] <= 1'b0;
			end
			if (cmd.finish) begin
				done <= 1'b1;
				if (func_q == FUNC_ADD && id_q != 32'd0) begin
					if (match_q) valid_q[match_idx_q] <= 1'b1;
					else if (free_q) valid_q[free_idx_q] <= 1'b1;
				end else if (func_q == FUNC_DEL && id_q != 32'd0 && match_q) begin
					valid_q[match_idx_q] <= 1'b0;
				end else if (func_q == FUNC_CLEAR) begin
					valid_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			id_q    <= node_id;
			px_q    <= pos_x;
			py_q    <= pos_y;
			ox_q    <= own_x;
			oy_q    <= own_y;
			now_q   <= now_time;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			have_q  <= 1'b0;
		end else if (cmd.step) begin
			if (live && r_addr == id_q && !match_q) begin
				match_q     <= 1'b1;
				match_idx_q <= idx_q;
			end
			if (!valid_q[idx_q] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (live && (!have_q || d < best_q || (d == best_q && r_addr < best_id_q))) begin
				have_q    <= 1'b1;
				best_q    <= d;
				best_id_q <= r_addr;
			end
		end else if (cmd.own_step) begin
			own_q <= d;
		end
		if (cmd.finish) begin
			next_hop        <= '0;
			hop_found       <= 1'b0;
			is_member       <= 1'b0;
			table_full_drop <= 1'b0;
			if (func_q == FUNC_ADD && id_q != 32'd0) begin
				if (match_q || free_q) begin
					addr_mem[match_q ? match_idx_q : free_idx_q]  <= id_q;
					x_mem[match_q ? match_idx_q : free_idx_q]     <= px_q;
					y_mem[match_q ? match_idx_q : free_idx_q]     <= py_q;
					stamp_mem[match_q ? match_idx_q : free_idx_q] <= now_q;
				end else begin
					table_full_drop <= 1'b1;
				end
			end else if (func_q == FUNC_CHECK && id_q != 32'd0) begin
				is_member <= match_q;
			end else if (func_q == FUNC_QUERY && have_q && best_q < own_q) begin
				next_hop  <= best_id_q;
				hop_found <= 1'b1;
			end
		end
	end

endmodule

// ----- hdl/greedy_geo_next_hop_table_top.sv -----
// greedy geographic next-hop neighbor table
// command channel: drive func, node_id, positions and now_time with start
// high; the command is taken at a clock edge where start is high and busy
// is low. busy is low again while the result is shown.
// result channel: next_hop, hop_found, is_member and table_full_drop are
// valid for exactly one cycle while done is high; there is no back pressure.
// every command scans all NEIGHBOR_SLOTS slots one per cycle through the
// shared distance unit, then computes the own distance and commits; done
// is registered from the commit state and no new command is taken until
// busy is low again. entry_lifetime is written with cfg_we and cfg_wdata;
// the user does so only while busy is low, the block does not enforce it.
// reset empties the table, sets the lifetime to 600000 us and idles the block.
module greedy_geo_next_hop_table_top
	import ggnh_pkg::*;
#(
	parameter int NEIGHBOR_SLOTS = 32,
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cfg_we,
	input  logic [31:0]                  cfg_wdata,
	input  logic [2:0]                   func,
	input  logic [31:0]                  node_id,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] own_x,
	input  logic signed [COORD_BITS-1:0] own_y,
	input  logic [47:0]                  now_time,
	output logic                         done,
	output logic [31:0]                  next_hop,
	output logic                         hop_found,
	output logic                         is_member,
	output logic                         table_full_drop
);

	ggnh_cmd_t cmd;
	ggnh_sts_t sts;

	ggnh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	ggnh_dp #(.NEIGHBOR_SLOTS(NEIGHBOR_SLOTS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.func(func), .node_id(node_id), .pos_x(pos_x), .pos_y(pos_y),
		.own_x(own_x), .own_y(own_y), .now_time(now_time),
		.next_hop(next_hop), .hop_found(hop_found), .is_member(is_member),
		.table_full_drop(table_full_drop), .done(done)
	);

endmodule

// ----- hdl/ggnh_checker.sv -----
`include "assert_macros.svh"

module ggnh_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic hop_found,
	input logic is_member,
	input logic table_full_drop,
	input logic [31:0] next_hop
);

	// an accepted transaction keeps the block busy
	`ASSERT_NEXT(a_busy_after_start, clk, arst_n, start && !busy, busy)
	// a result is a single cycle pulse
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// the result is shown while the block is idle again
	`ASSERT_SAME(a_idle_with_done, clk, arst_n, done, !busy)
	// a found hop is never the invalid address
	`ASSERT_SAME(a_hop_nonzero, clk, arst_n, done && hop_found, next_hop != 32'd0)
	// only one kind of result flag at a time
	`ASSERT_SAME(a_one_flag, clk, arst_n, done,
		$countones({hop_found, is_member, table_full_drop}) <= 1)

endmodule

bind greedy_geo_next_hop_table_top ggnh_checker u_ggnh_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.hop_found(hop_found), .is_member(is_member),
	.table_full_drop(table_full_drop), .next_hop(next_hop)
);
